// ===== src/indexed_list_store_defines.svh =====
// ----------------------------------------------------------------------------
// Indexed list store assertion macros
// Concurrent checks on clk with asynchronous reset arst_n, removed in synthesis.
// ----------------------------------------------------------------------------
`ifndef INDEXED_LIST_STORE_DEFINES_SVH
`define INDEXED_LIST_STORE_DEFINES_SVH

`ifndef SYNTHESIS
`define ILS_ASSERT_SAME(label, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error("indexed list store check failed");
`define ILS_ASSERT_NEXT(label, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error("indexed list store check failed");
`else
`define ILS_ASSERT_SAME(label, ante, cons)
`define ILS_ASSERT_NEXT(label, ante, cons)
`endif

`endif

// ===== src/ils_pkg.sv =====
// ----------------------------------------------------------------------------
// Indexed list store package
// Sizes, request and status codes, cell control and scan types.
// ----------------------------------------------------------------------------
package ils_pkg;

	localparam int DEPTH = 16;
	localparam int DATA_W = 32;
	localparam int POS_W = 4;
	localparam int CNT_W = $clog2(DEPTH + 1);
	localparam int IDX_W = $clog2(DEPTH);
	localparam int CMP_W = (CNT_W > POS_W) ? CNT_W : POS_W;

	typedef enum logic [2:0] {
		REQ_APPEND     = 3'd0,
		REQ_PREPEND    = 3'd1,
		REQ_DROP_BACK  = 3'd2,
		REQ_DROP_FRONT = 3'd3,
		REQ_READ       = 3'd4,
		REQ_WRITE      = 3'd5,
		REQ_REMOVE_AT  = 3'd6,
		REQ_CLEAR      = 3'd7
	} req_t;

	typedef enum logic [1:0] {
		STAT_OK    = 2'd0,
		STAT_POS   = 2'd1,
		STAT_EMPTY = 2'd2,
		STAT_FULL  = 2'd3
	} status_t;

	typedef enum logic [1:0] {
		CELL_HOLD,
		CELL_LOAD,
		CELL_FROM_LEFT,
		CELL_FROM_RIGHT
	} cell_op_t;

	typedef enum logic [1:0] {
		ST_IDLE,
		ST_SCAN,
		ST_DONE
	} state_t;

	typedef struct packed {
		cell_op_t op;
		logic     live;
	} cell_ctl_t;

	typedef struct packed {
		logic              vld;
		logic [DATA_W-1:0] hi;
		logic [DATA_W-1:0] lo;
	} scan_t;

endpackage

// ===== src/ils_if.sv =====
// ----------------------------------------------------------------------------
// Indexed list store channels
// Request and response channels with valid/ready handshake.
// ----------------------------------------------------------------------------
interface ils_req_if;
	logic                     valid;
	logic                     ready;
	logic [2:0]               req_type;
	logic [3:0]               position;
	logic signed [31:0]       data_in;

	modport source (output valid, req_type, position, data_in, input ready);
	modport sink (input valid, req_type, position, data_in, output ready);
endinterface

interface ils_rsp_if;
	logic                     valid;
	logic                     ready;
	logic signed [31:0]       read_value;
	logic [4:0]               count;
	logic signed [31:0]       largest;
	logic signed [31:0]       smallest;
	logic [1:0]               status;

	modport source (output valid, read_value, count, largest, smallest, status, input ready);
	modport sink (input valid, read_value, count, largest, smallest, status, output ready);
endinterface

// ===== src/ils_cell.sv =====
// ----------------------------------------------------------------------------
// Indexed list store cell
// Holds one element, shifts with its neighbors and extends the min/max scan.
// ----------------------------------------------------------------------------
module ils_cell (
	input  logic                            clk,
	input  ils_pkg::cell_ctl_t              ctl,
	input  logic [ils_pkg::DATA_W-1:0]      load_val,
	input  logic [ils_pkg::DATA_W-1:0]      left_val,
	input  logic [ils_pkg::DATA_W-1:0]      right_val,
	input  ils_pkg::scan_t                  scan_in,
	output logic [ils_pkg::DATA_W-1:0]      val,
	output ils_pkg::scan_t                  scan_out
);

	logic [ils_pkg::DATA_W-1:0] val_q;
	ils_pkg::scan_t             scan_q;
	ils_pkg::scan_t             scan_d;

	always_ff @(posedge clk) begin
		case (ctl.op)
			ils_pkg::CELL_LOAD:       val_q <= load_val;
			ils_pkg::CELL_FROM_LEFT:  val_q <= left_val;
			ils_pkg::CELL_FROM_RIGHT: val_q <= right_val;
			default:                  val_q <= val_q;
		endcase
	end

	always_comb begin
		scan_d = scan_in;
		if (ctl.live) begin
			if (!scan_in.vld) begin
				scan_d.vld = 1'b1;
				scan_d.hi  = val_q;
				scan_d.lo  = val_q;
			end else begin
				if ($signed(val_q) > $signed(scan_in.hi)) begin
					scan_d.hi = val_q;
				end
				if ($signed(val_q) < $signed(scan_in.lo)) begin
					scan_d.lo = val_q;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		scan_q <= scan_d;
	end

	assign val      = val_q;
	assign scan_out = scan_q;

endmodule

// ===== src/indexed_list_store.sv =====
// ----------------------------------------------------------------------------
// Indexed list store
// Bounded ordered list of signed words held in a row of shifting cells.
// ----------------------------------------------------------------------------
// The req channel carries one request word: req_type, position and data_in.
// The rsp channel returns one word per request: read_value, count, largest,
// smallest and status. Both channels use a valid/ready handshake.
// A request is applied to the cells at the edge that accepts it. The minimum
// and maximum then ripple through the cell row one cell per cycle, and the
// response is loaded into the output register when the scan leaves the last
// cell. No new request is taken from acceptance until that load.
// A new request is taken while the previous response still waits in the
// output register; a finished response that finds the register occupied
// waits until the receiver takes the old word, and no request is accepted
// meanwhile. Reset empties the list and drops any pending response; cell
// contents are not cleared since only cells below the count are ever read.
// ----------------------------------------------------------------------------
`include "indexed_list_store_defines.svh"

module indexed_list_store (
	input  logic          clk,
	input  logic          arst_n,
	ils_req_if.sink       req,
	ils_rsp_if.source     rsp
);

	localparam int DEPTH  = ils_pkg::DEPTH;
	localparam int DATA_W = ils_pkg::DATA_W;
	localparam int CNT_W  = ils_pkg::CNT_W;
	localparam int IDX_W  = ils_pkg::IDX_W;
	localparam int CMP_W  = ils_pkg::CMP_W;

	ils_pkg::state_t    state_q, state_d;
	logic [IDX_W-1:0]   scan_cnt_q;
	logic [CNT_W-1:0]   fill_q, fill_d;
	logic [DATA_W-1:0]  pend_rd_q, rd_d;
	ils_pkg::status_t   pend_status_q, status_d;

	logic               rsp_valid_q;
	logic [DATA_W-1:0]  rsp_rd_q, rsp_hi_q, rsp_lo_q;
	logic [4:0]         rsp_count_q;
	ils_pkg::status_t   rsp_status_q;

	logic               accept, load_rsp, in_ready;
	logic               full, empty, pos_ok;
	logic [CMP_W-1:0]   pos_ext, fill_ext;
	ils_pkg::req_t      req_code;

	logic [DATA_W-1:0]  cell_val [DEPTH];
	ils_pkg::scan_t     cell_scan [DEPTH];
	ils_pkg::cell_ctl_t cell_ctl [DEPTH];

	assign accept   = req.valid && in_ready;
	assign req_code = ils_pkg::req_t'(req.req_type);
	assign full     = (fill_q == CNT_W'(DEPTH));
	assign empty    = (fill_q == '0);
	assign pos_ext  = CMP_W'(req.position);
	assign fill_ext = CMP_W'(fill_q);
	assign pos_ok   = (pos_ext < fill_ext);

	always_comb begin
		fill_d   = fill_q;
		rd_d     = '0;
		status_d = ils_pkg::STAT_OK;
		case (req_code)
			ils_pkg::REQ_APPEND, ils_pkg::REQ_PREPEND: begin
				if (full) begin
					status_d = ils_pkg::STAT_FULL;
				end else begin
					fill_d = fill_q + CNT_W'(1);
				end
			end
			ils_pkg::REQ_DROP_BACK, ils_pkg::REQ_DROP_FRONT: begin
				if (empty) begin
					status_d = ils_pkg::STAT_EMPTY;
				end else begin
					fill_d = fill_q - CNT_W'(1);
				end
			end
			ils_pkg::REQ_READ: begin
				if (!pos_ok) begin
					status_d = ils_pkg::STAT_POS;
				end else begin
					for (int i = 0; i < DEPTH; i++) begin
						if (CMP_W'(i) == pos_ext) begin
							rd_d = cell_val[i];
						end
					end
				end
			end
			ils_pkg::REQ_WRITE: begin
				if (!pos_ok) begin
					status_d = ils_pkg::STAT_POS;
				end
			end
			ils_pkg::REQ_REMOVE_AT: begin
				if (!pos_ok) begin
					status_d = ils_pkg::STAT_POS;
				end else begin
					fill_d = fill_q - CNT_W'(1);
				end
			end
			default: begin
				fill_d = '0;
			end
		endcase
	end

	for (genvar gi = 0; gi < DEPTH; gi++) begin : g_cell
		logic [DATA_W-1:0] left_val, right_val;
		ils_pkg::scan_t    scan_in;

		always_comb begin
			cell_ctl[gi].op   = ils_pkg::CELL_HOLD;
			cell_ctl[gi].live = (CNT_W'(gi) < fill_q);
			if (accept) begin
				case (req_code)
					ils_pkg::REQ_APPEND: begin
						if (!full && fill_q == CNT_W'(gi)) begin
							cell_ctl[gi].op = ils_pkg::CELL_LOAD;
						end
					end
					ils_pkg::REQ_PREPEND: begin
						if (!full) begin
							cell_ctl[gi].op = (gi == 0) ? ils_pkg::CELL_LOAD
								: ils_pkg::CELL_FROM_LEFT;
						end
					end
					ils_pkg::REQ_DROP_FRONT: begin
						if (!empty) begin
							cell_ctl[gi].op = ils_pkg::CELL_FROM_RIGHT;
						end
					end
					ils_pkg::REQ_WRITE: begin
						if (pos_ok && pos_ext == CMP_W'(gi)) begin
							cell_ctl[gi].op = ils_pkg::CELL_LOAD;
						end
					end
					ils_pkg::REQ_REMOVE_AT: begin
						if (pos_ok && CMP_W'(gi) >= pos_ext) begin
							cell_ctl[gi].op = ils_pkg::CELL_FROM_RIGHT;
						end
					end
					default: begin
						cell_ctl[gi].op = ils_pkg::CELL_HOLD;
					end
				endcase
			end
		end

		if (gi == 0) begin : g_first
			assign left_val = '0;
			assign scan_in  = '0;
		end else begin : g_mid
			assign left_val = cell_val[gi-1];
			assign scan_in  = cell_scan[gi-1];
		end

		if (gi == DEPTH - 1) begin : g_last
			assign right_val = '0;
		end else begin : g_inner
			assign right_val = cell_val[gi+1];
		end

		ils_cell u_cell (
			.clk       (clk),
			.ctl       (cell_ctl[gi]),
			.load_val  (req.data_in),
			.left_val  (left_val),
			.right_val (right_val),
			.scan_in   (scan_in),
			.val       (cell_val[gi]),
			.scan_out  (cell_scan[gi])
		);
	end

	always_comb begin
		state_d = state_q;
		case (state_q)
			ils_pkg::ST_IDLE: begin
				if (req.valid) begin
					state_d = ils_pkg::ST_SCAN;
				end
			end
			ils_pkg::ST_SCAN: begin
				if (scan_cnt_q == '0) begin
					state_d = ils_pkg::ST_DONE;
				end
			end
			ils_pkg::ST_DONE: begin
				if (!rsp_valid_q || rsp.ready) begin
					state_d = ils_pkg::ST_IDLE;
				end
			end
			default: begin
				state_d = ils_pkg::ST_IDLE;
			end
		endcase
	end

	always_comb begin
		in_ready = 1'b0;
		load_rsp = 1'b0;
		case (state_q)
			ils_pkg::ST_IDLE: in_ready = 1'b1;
			ils_pkg::ST_DONE: load_rsp = !rsp_valid_q || rsp.ready;
			default: begin
				in_ready = 1'b0;
				load_rsp = 1'b0;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ils_pkg::ST_IDLE;
			fill_q      <= '0;
			scan_cnt_q  <= '0;
			rsp_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			if (accept) begin
				fill_q     <= fill_d;
				scan_cnt_q <= IDX_W'(DEPTH - 1);
			end else if (state_q == ils_pkg::ST_SCAN && scan_cnt_q != '0) begin
				scan_cnt_q <= scan_cnt_q - IDX_W'(1);
			end
			if (load_rsp) begin
				rsp_valid_q <= 1'b1;
			end else if (rsp.ready) begin
				rsp_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			pend_rd_q     <= rd_d;
			pend_status_q <= status_d;
		end
		if (load_rsp) begin
			rsp_rd_q     <= pend_rd_q;
			rsp_count_q  <= fill_q[4:0];
			rsp_hi_q     <= cell_scan[DEPTH-1].vld ? cell_scan[DEPTH-1].hi : '0;
			rsp_lo_q     <= cell_scan[DEPTH-1].vld ? cell_scan[DEPTH-1].lo : '0;
			rsp_status_q <= pend_status_q;
		end
	end

	assign req.ready      = in_ready;
	assign rsp.valid      = rsp_valid_q;
	assign rsp.read_value = rsp_rd_q;
	assign rsp.count      = rsp_count_q;
	assign rsp.largest    = rsp_hi_q;
	assign rsp.smallest   = rsp_lo_q;
	assign rsp.status     = rsp_status_q;

	`ILS_ASSERT_SAME(a_fill_bound, 1'b1, fill_q <= CNT_W'(DEPTH))
	`ILS_ASSERT_NEXT(a_accept_scan, accept, state_q == ils_pkg::ST_SCAN)
	`ILS_ASSERT_NEXT(a_rsp_count, load_rsp, rsp_valid_q && rsp_count_q == fill_q[4:0])
	`ILS_ASSERT_SAME(a_rsp_order, rsp_valid_q, $signed(rsp_lo_q) <= $signed(rsp_hi_q))

endmodule

// ===== verif/indexed_list_store_tb.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Indexed list store testbench
// A queue-fed driver sends a short directed sequence and then phased random
// requests that grow the list, shrink it or mix operations. A monitor predicts
// every response from a shadow copy of the list and compares it field by field.
// Both sides idle at random, the receiver once holds off long enough to stall
// the block, and the sender at times waits until every response is back.
// ----------------------------------------------------------------------------
module indexed_list_store_tb;

	localparam int DEPTH = ils_pkg::DEPTH;
	localparam int DATA_W = ils_pkg::DATA_W;
	localparam int POS_W = ils_pkg::POS_W;
	localparam int CNT_W = ils_pkg::CNT_W;

	localparam int RANDOM_ITEMS = 1020;
	localparam int HOLD_AT = 300;
	localparam int HOLD_LEN = 150;
	localparam int IDLE_LIMIT = 3000;
	localparam int TAIL_CYCLES = 2 * DEPTH + 8;
	localparam int MAX_PRINTS = 40;

	typedef struct {
		ils_pkg::req_t     op;
		logic [POS_W-1:0]  position;
		logic signed [DATA_W-1:0] value;
		int                gap;
		bit                wait_drain;
	} list_req_t;

	typedef struct {
		logic signed [DATA_W-1:0] read_value;
		logic [CNT_W-1:0]         count;
		logic signed [DATA_W-1:0] largest;
		logic signed [DATA_W-1:0] smallest;
		ils_pkg::status_t         status;
	} list_result_t;

	logic clk = 1'b0;
	logic arst_n = 1'b0;

	ils_req_if req_bus ();
	ils_rsp_if rsp_bus ();

	indexed_list_store i_dut (
		.clk    (clk),
		.arst_n (arst_n),
		.req    (req_bus),
		.rsp    (rsp_bus)
	);

	always #5 clk = ~clk;

	list_req_t pending_items[$];
	list_result_t expected_results[$];
	list_req_t cur_item;
	list_result_t got_word;
	list_result_t want_word;
	list_result_t new_word;

	logic signed [DATA_W-1:0] shadow_cells [DEPTH];
	int shadow_fill = 0;
	int peak_fill = 0;

	int error_count = 0;
	int total_items = 0;
	int accepted_reqs = 0;
	int outstanding = 0;
	int rcvd_words = 0;
	int full_refusals = 0;
	int empty_refusals = 0;
	int pos_refusals = 0;
	int clear_count = 0;
	int gap_left = 0;
	int stall_left = 0;
	int hold_left = 0;
	int idle_cycles = 0;
	bit gen_burst = 1'b0;

	task automatic report_error(input string msg);
		if (error_count < MAX_PRINTS)
			$display("ERROR at %0t ns: %s", $time, msg);
		error_count++;
	endtask

	task automatic push_item(input ils_pkg::req_t op, input int pos,
			input logic signed [DATA_W-1:0] value, input bit drain);
		list_req_t it;
		it.op = op;
		it.position = POS_W'(pos);
		it.value = value;
		it.gap = gen_burst ? 0 : $urandom_range(0, 9);
		it.wait_drain = drain;
		pending_items.insert(pending_items.size(), it);
	endtask

	function automatic logic signed [DATA_W-1:0] pick_value();
		case ($urandom_range(0, 9))
			0: return 32'h7fff_ffff;
			1: return 32'h8000_0000;
			2: return 32'sd0;
			3: return -32'sd1;
			4, 5: return $signed(32'($urandom_range(0, 15))) - 32'sd8;
			default: return $urandom();
		endcase
	endfunction

	// Applies one request to the shadow list and returns the response it earns.
	function automatic list_result_t apply_request(input ils_pkg::req_t op,
			input logic [POS_W-1:0] position, input logic signed [DATA_W-1:0] value);
		list_result_t res;
		int p;
		int i;
		res.read_value = '0;
		res.largest = '0;
		res.smallest = '0;
		res.status = ils_pkg::STAT_OK;
		p = int'(position);
		case (op)
			ils_pkg::REQ_APPEND: begin
				if (shadow_fill >= DEPTH) begin
					res.status = ils_pkg::STAT_FULL;
				end else begin
					shadow_cells[shadow_fill] = value;
					shadow_fill++;
				end
			end
			ils_pkg::REQ_PREPEND: begin
				if (shadow_fill >= DEPTH) begin
					res.status = ils_pkg::STAT_FULL;
				end else begin
					for (i = shadow_fill; i > 0; i--)
						shadow_cells[i] = shadow_cells[i-1];
					shadow_cells[0] = value;
					shadow_fill++;
				end
			end
			ils_pkg::REQ_DROP_BACK: begin
				if (shadow_fill == 0)
					res.status = ils_pkg::STAT_EMPTY;
				else
					shadow_fill--;
			end
			ils_pkg::REQ_DROP_FRONT: begin
				if (shadow_fill == 0) begin
					res.status = ils_pkg::STAT_EMPTY;
				end else begin
					for (i = 0; i + 1 < shadow_fill; i++)
						shadow_cells[i] = shadow_cells[i+1];
					shadow_fill--;
				end
			end
			ils_pkg::REQ_READ: begin
				if (p >= shadow_fill)
					res.status = ils_pkg::STAT_POS;
				else
					res.read_value = shadow_cells[p];
			end
			ils_pkg::REQ_WRITE: begin
				if (p >= shadow_fill)
					res.status = ils_pkg::STAT_POS;
				else
					shadow_cells[p] = value;
			end
			ils_pkg::REQ_REMOVE_AT: begin
				if (p >= shadow_fill) begin
					res.status = ils_pkg::STAT_POS;
				end else begin
					for (i = p; i + 1 < shadow_fill; i++)
						shadow_cells[i] = shadow_cells[i+1];
					shadow_fill--;
				end
			end
			default: begin
				shadow_fill = 0;
			end
		endcase
		if (shadow_fill > 0) begin
			res.largest = shadow_cells[0];
			res.smallest = shadow_cells[0];
			for (i = 1; i < shadow_fill; i++) begin
				if (shadow_cells[i] > res.largest)
					res.largest = shadow_cells[i];
				if (shadow_cells[i] < res.smallest)
					res.smallest = shadow_cells[i];
			end
		end
		res.count = CNT_W'(shadow_fill);
		return res;
	endfunction

	// A request flagged to wait for drain is only offered from an idle channel,
	// so the outstanding count it reads already includes the previous word.
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			req_bus.valid <= 1'b0;
			gap_left = pending_items.size() > 0 ? pending_items[0].gap : 0;
		end else begin
			if (req_bus.valid && req_bus.ready) begin
				gap_left = pending_items.size() > 0 ? pending_items[0].gap : 0;
				req_bus.valid <= 1'b0;
			end else if (!req_bus.valid) begin
				if (gap_left > 0) begin
					gap_left--;
				end else if (pending_items.size() > 0 &&
						(!pending_items[0].wait_drain || outstanding == 0)) begin
					cur_item = pending_items[0];
					pending_items.delete(0);
					req_bus.req_type <= cur_item.op;
					req_bus.position <= cur_item.position;
					req_bus.data_in <= cur_item.value;
					req_bus.valid <= 1'b1;
				end
			end
		end
	end

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rsp_bus.ready <= 1'b0;
			stall_left = 0;
			hold_left = 0;
		end else begin
			if (rsp_bus.valid && rsp_bus.ready) begin
				rcvd_words++;
				got_word.read_value = rsp_bus.read_value;
				got_word.count = rsp_bus.count;
				got_word.largest = rsp_bus.largest;
				got_word.smallest = rsp_bus.smallest;
				got_word.status = ils_pkg::status_t'(rsp_bus.status);
				if (expected_results.size() == 0) begin
					report_error("response word with no request waiting");
				end else begin
					want_word = expected_results[0];
					expected_results.delete(0);
					if (got_word.read_value !== want_word.read_value)
						report_error($sformatf("word %0d read_value %0d, expected %0d", rcvd_words,
							got_word.read_value, want_word.read_value));
					if (got_word.count !== want_word.count)
						report_error($sformatf("word %0d count %0d, expected %0d", rcvd_words,
							got_word.count, want_word.count));
					if (got_word.largest !== want_word.largest)
						report_error($sformatf("word %0d largest %0d, expected %0d", rcvd_words,
							got_word.largest, want_word.largest));
					if (got_word.smallest !== want_word.smallest)
						report_error($sformatf("word %0d smallest %0d, expected %0d", rcvd_words,
							got_word.smallest, want_word.smallest));
					if (got_word.status !== want_word.status)
						report_error($sformatf("word %0d status %0d, expected %0d", rcvd_words,
							rsp_bus.status, want_word.status));
				end
				stall_left = ((rcvd_words / 60) % 4 == 0) ? 0 : $urandom_range(0, 9);
				if (rcvd_words == HOLD_AT)
					hold_left = HOLD_LEN;
			end
			if (req_bus.valid && req_bus.ready) begin
				new_word = apply_request(ils_pkg::req_t'(req_bus.req_type), req_bus.position,
					req_bus.data_in);
				expected_results.insert(expected_results.size(), new_word);
				accepted_reqs <= accepted_reqs + 1;
				if (shadow_fill > peak_fill)
					peak_fill = shadow_fill;
				case (new_word.status)
					ils_pkg::STAT_FULL: full_refusals++;
					ils_pkg::STAT_EMPTY: empty_refusals++;
					ils_pkg::STAT_POS: pos_refusals++;
					default: if (req_bus.req_type == ils_pkg::REQ_CLEAR) clear_count++;
				endcase
			end
			outstanding <= expected_results.size();
			if (hold_left > 0) begin
				hold_left--;
				rsp_bus.ready <= 1'b0;
			end else if (stall_left > 0) begin
				stall_left--;
				rsp_bus.ready <= 1'b0;
			end else begin
				rsp_bus.ready <= 1'b1;
			end
		end
	end

	always @(posedge clk) begin
		if ((req_bus.valid && req_bus.ready) || (rsp_bus.valid && rsp_bus.ready))
			idle_cycles = 0;
		else
			idle_cycles++;
		if (idle_cycles >= IDLE_LIMIT) begin
			$display("Timeout: no word moved for %0d cycles, %0d responses still due",
				IDLE_LIMIT, expected_results.size());
			$display("DONE: errors detected");
			$finish;
		end
	end

	initial begin
		int n;
		int k;
		int mode;
		int w;
		int gen_fill;
		int pos;
		ils_pkg::req_t op;
		logic signed [DATA_W-1:0] val;

		req_bus.valid = 1'b0;
		req_bus.req_type = ils_pkg::REQ_CLEAR;
		req_bus.position = '0;
		req_bus.data_in = '0;
		rsp_bus.ready = 1'b0;

		push_item(ils_pkg::REQ_DROP_BACK, 0, 32'sd0, 1'b0);
		push_item(ils_pkg::REQ_DROP_FRONT, 15, -32'sd1, 1'b0);
		push_item(ils_pkg::REQ_READ, 0, 32'sd0, 1'b0);
		push_item(ils_pkg::REQ_REMOVE_AT, 15, 32'sd0, 1'b0);
		push_item(ils_pkg::REQ_CLEAR, 0, 32'sd0, 1'b0);
		push_item(ils_pkg::REQ_APPEND, 0, 32'h7fff_ffff, 1'b0);
		push_item(ils_pkg::REQ_DROP_BACK, 0, 32'sd0, 1'b0);
		for (k = 0; k < DEPTH; k++) begin
			case (k % 4)
				0: val = 32'h8000_0000;
				1: val = 32'h7fff_ffff;
				2: val = (k & 4) ? 32'haaaa_aaaa : 32'h5555_5555;
				default: val = -k;
			endcase
			push_item((k % 2) ? ils_pkg::REQ_PREPEND : ils_pkg::REQ_APPEND, k, val, 1'b0);
		end
		push_item(ils_pkg::REQ_APPEND, 0, 32'sd1, 1'b0);
		push_item(ils_pkg::REQ_PREPEND, 0, 32'sd2, 1'b0);
		push_item(ils_pkg::REQ_READ, 15, 32'sd0, 1'b0);
		push_item(ils_pkg::REQ_WRITE, 15, 32'sd0, 1'b0);
		push_item(ils_pkg::REQ_REMOVE_AT, 0, 32'sd0, 1'b0);
		push_item(ils_pkg::REQ_WRITE, 15, 32'sd5, 1'b0);
		push_item(ils_pkg::REQ_DROP_FRONT, 0, 32'sd0, 1'b0);
		push_item(ils_pkg::REQ_CLEAR, 0, 32'sd0, 1'b0);

		gen_fill = 0;
		mode = 0;
		for (n = 0; n < RANDOM_ITEMS; n++) begin
			if (n % 40 == 0)
				mode = $urandom_range(0, 2);
			if (n % 50 == 0)
				gen_burst = ($urandom_range(0, 3) == 0);
			w = $urandom_range(0, 99);
			case (mode)
				0: begin
					if (w < 60) op = ($urandom_range(0, 1) == 0) ? ils_pkg::REQ_APPEND
						: ils_pkg::REQ_PREPEND;
					else if (w < 85) op = ($urandom_range(0, 1) == 0) ? ils_pkg::REQ_READ
						: ils_pkg::REQ_WRITE;
					else if (w < 95) op = ($urandom_range(0, 1) == 0) ? ils_pkg::REQ_DROP_BACK
						: ils_pkg::REQ_DROP_FRONT;
					else if (w < 99) op = ils_pkg::REQ_REMOVE_AT;
					else op = ils_pkg::REQ_CLEAR;
				end
				1: begin
					if (w < 50) op = ($urandom_range(0, 1) == 0) ? ils_pkg::REQ_DROP_BACK
						: ils_pkg::REQ_DROP_FRONT;
					else if (w < 70) op = ils_pkg::REQ_REMOVE_AT;
					else if (w < 90) op = ($urandom_range(0, 1) == 0) ? ils_pkg::REQ_READ
						: ils_pkg::REQ_WRITE;
					else if (w < 98) op = ($urandom_range(0, 1) == 0) ? ils_pkg::REQ_APPEND
						: ils_pkg::REQ_PREPEND;
					else op = ils_pkg::REQ_CLEAR;
				end
				default: begin
					op = (w < 2) ? ils_pkg::REQ_CLEAR : ils_pkg::req_t'($urandom_range(0, 6));
				end
			endcase
			if ((op == ils_pkg::REQ_READ || op == ils_pkg::REQ_WRITE ||
					op == ils_pkg::REQ_REMOVE_AT) && gen_fill > 0 &&
					$urandom_range(0, 9) < 8)
				pos = $urandom_range(0, gen_fill - 1);
			else
				pos = $urandom_range(0, 15);
			val = (op == ils_pkg::REQ_APPEND || op == ils_pkg::REQ_PREPEND ||
				op == ils_pkg::REQ_WRITE) ? pick_value() : $urandom();
			case (op)
				ils_pkg::REQ_APPEND, ils_pkg::REQ_PREPEND: if (gen_fill < DEPTH) gen_fill++;
				ils_pkg::REQ_DROP_BACK, ils_pkg::REQ_DROP_FRONT: if (gen_fill > 0) gen_fill--;
				ils_pkg::REQ_REMOVE_AT: if (pos < gen_fill) gen_fill--;
				ils_pkg::REQ_CLEAR: gen_fill = 0;
				default: ;
			endcase
			push_item(op, pos, val, n % 250 == 0);
		end
		total_items = pending_items.size();

		repeat (4) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		while (accepted_reqs != total_items || outstanding != 0)
			@(posedge clk);
		repeat (TAIL_CYCLES) @(posedge clk);
		if (expected_results.size() != 0)
			report_error($sformatf("%0d responses never arrived", expected_results.size()));

		$display("Summary: %0d requests, %0d responses, list filled up to %0d of %0d cells.",
			accepted_reqs, rcvd_words, peak_fill, DEPTH);
		$display("Refused: %0d on a full list, %0d on an empty list, %0d bad positions; %0d clears.",
			full_refusals, empty_refusals, pos_refusals, clear_count);
		if (error_count == 0) begin
			$display("DONE: 0 errors");
		end else begin
			$display("DONE: errors detected");
		end
		$finish;
	end

endmodule

// ===== filelist.f =====
+incdir+src
src/ils_pkg.sv
src/ils_if.sv
src/ils_cell.sv
src/indexed_list_store.sv
verif/indexed_list_store_tb.sv
